@@ rtl/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned MaxTasksDef = 16;
  localparam int unsigned StackW      = 32;
  localparam int unsigned TickW       = 32;
  localparam int unsigned PidW        = 16;
  localparam int unsigned ErrW        = 2;
  localparam int unsigned RemovedW    = 5;
  localparam int unsigned OpW         = 3;
  localparam int unsigned InDataW     = StackW + TickW;
  localparam int unsigned OutDataW    = 72;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 3'd0,
    OP_YIELD  = 3'd1,
    OP_SLEEP  = 3'd2,
    OP_CREATE = 3'd3,
    OP_END    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    TS_NEW   = 3'd0,
    TS_RUN   = 3'd1,
    TS_SLEEP = 3'd2,
    TS_WAIT  = 3'd3,
    TS_STOP  = 3'd4,
    TS_ENDED = 3'd5,
    TS_FREE  = 3'd6
  } task_st_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK       = 2'd0,
    ERR_FULL     = 2'd1,
    ERR_IDLE_END = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_WALK,
    S_READ,
    S_LOAD
  } fsm_e;

endpackage

@@ rtl/rrts_ram.sv @@
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/round_robin_task_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Ring-ordered task table with sleep timers and a one-slot-per-cycle walker.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Operations that neither create nor switch
// answer in the cycle after acceptance. A create scans the table for the
// lowest free slot at one slot per cycle. A switch walks the ring one slot
// per cycle (an unlinked task costs one step as well), is bounded by
// MAX_TASKS+1 steps, the last of which falls back to the idle task, and then
// reads the resumed stack from the stack RAM in S_READ and S_LOAD. The input
// is not ready while an item is in progress or a result beat is still
// waiting to be taken.
module round_robin_task_scheduler_unit #(
  parameter int unsigned MAX_TASKS = rrts_pkg::MaxTasksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,      // scheduler_enable
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] stack_value, [63:32] sleep_ticks
  input  logic [rrts_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [2:0] opcode
  input  logic [rrts_pkg::OpW-1:0]      s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] resume_stack, [47:32] running_pid, [63:48] created_pid,
  // [65:64] error_code, [70:66] removed_count, [71] zero
  output logic [rrts_pkg::OutDataW-1:0] m_axis_tdata_o
);

  import rrts_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_TASKS);
  localparam int unsigned PtrW = IdxW + 1;
  localparam logic [PtrW-1:0] Null = PtrW'(MAX_TASKS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_TASKS - 1);

  task_st_e        status_q [MAX_TASKS];
  logic [PidW-1:0] pid_q    [MAX_TASKS];
  logic [TickW-1:0] wake_q  [MAX_TASKS];
  logic [PtrW-1:0] next_q   [MAX_TASKS];
  logic [PtrW-1:0] prev_q   [MAX_TASKS];

  fsm_e             state_q, state_d;
  logic             en_q;
  logic [IdxW-1:0]  cur_q;
  logic [TickW-1:0] tick_q;
  logic [PidW-1:0]  next_pid_q;
  logic [IdxW-1:0]  idx_q;
  logic [PtrW-1:0]  visits_q;
  logic [RemovedW-1:0] removed_q;
  logic [StackW-1:0] hold_q;

  logic              out_valid_q;
  logic [StackW-1:0] out_stack_q;
  logic [PidW-1:0]   out_pid_q;
  logic [PidW-1:0]   out_created_q;
  err_e              out_err_q;
  logic [RemovedW-1:0] out_removed_q;

  logic              s_fire;
  op_e               op;
  logic [StackW-1:0] in_stack;
  logic [TickW-1:0]  in_ticks;
  logic              do_switch;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [StackW-1:0] ram_wdata;
  logic [StackW-1:0] ram_rdata;

  // Walker step signals.
  logic [IdxW-1:0]  succ;
  task_st_e         w_st;
  logic             w_run;
  logic             w_end;
  logic [PtrW-1:0]  w_prev;
  logic [PtrW-1:0]  w_next;
  logic             f_hit;

  assign s_axis_tready_o = (state_q == S_IDLE) && !out_valid_q;
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign op       = op_e'(s_axis_tuser_i);
  assign in_stack = s_axis_tdata_i[StackW-1:0];
  assign in_ticks = s_axis_tdata_i[InDataW-1:StackW];

  always_comb begin
    do_switch = 1'b0;
    case (op)
      OP_TICK, OP_YIELD, OP_SLEEP: do_switch = en_q;
      OP_END:                      do_switch = en_q && (cur_q != '0);
      default:                     do_switch = 1'b0;
    endcase
  end

  always_comb begin
    succ   = (next_q[cur_q] >= Null) ? '0 : next_q[cur_q][IdxW-1:0];
    w_st   = status_q[succ];
    w_prev = prev_q[succ];
    w_next = next_q[succ];
    w_end  = (w_st == TS_ENDED) && (succ != '0);
    w_run  = (w_st == TS_NEW) || (w_st == TS_WAIT) || (w_st == TS_RUN) ||
             ((w_st == TS_SLEEP) && (wake_q[succ] <= tick_q));
    f_hit  = (status_q[idx_q] == TS_FREE);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = in_stack;
    if (s_fire && do_switch) begin
      ram_we = 1'b1;
    end else if (state_q == S_FIND && f_hit) begin
      ram_we    = 1'b1;
      ram_waddr = idx_q;
      ram_wdata = hold_q;
    end
  end

  rrts_ram #(
    .Width (StackW),
    .Depth (MAX_TASKS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cur_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (op == OP_CREATE) begin
            state_d = S_FIND;
          end else if (do_switch) begin
            state_d = S_WALK;
          end
        end
      end
      S_FIND: begin
        if (f_hit || idx_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        if (visits_q >= Null || (!w_end && w_run)) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_LOAD;
      S_LOAD:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        status_q[i] <= (i == 0) ? TS_RUN : TS_FREE;
        pid_q[i]    <= '0;
        wake_q[i]   <= '0;
        next_q[i]   <= Null;
        prev_q[i]   <= Null;
      end
      en_q          <= 1'b0;
      cur_q         <= '0;
      tick_q        <= '0;
      next_pid_q    <= PidW'(1);
      idx_q         <= '0;
      visits_q      <= '0;
      removed_q     <= '0;
      hold_q        <= '0;
      out_valid_q   <= 1'b0;
      out_stack_q   <= '0;
      out_pid_q     <= '0;
      out_created_q <= '0;
      out_err_q     <= ERR_OK;
      out_removed_q <= '0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            hold_q        <= in_stack;
            idx_q         <= IdxW'(1);
            visits_q      <= '0;
            removed_q     <= '0;
            out_stack_q   <= in_stack;
            out_pid_q     <= pid_q[cur_q];
            out_created_q <= '0;
            out_err_q     <= (op == OP_END && cur_q == '0) ? ERR_IDLE_END : ERR_OK;
            out_removed_q <= '0;
            if (op == OP_TICK) begin
              tick_q <= tick_q + TickW'(1);
            end
            if (op == OP_SLEEP && en_q) begin
              status_q[cur_q] <= TS_SLEEP;
              wake_q[cur_q]   <= tick_q + in_ticks;
            end else if (op == OP_END && cur_q != '0) begin
              status_q[cur_q] <= TS_ENDED;
            end else if (do_switch && status_q[cur_q] == TS_RUN) begin
              status_q[cur_q] <= TS_WAIT;
            end
            // Beats that neither create nor switch answer right away.
            out_valid_q <= (op != OP_CREATE) && !do_switch;
          end
        end
        S_FIND: begin
          if (f_hit) begin
            status_q[idx_q] <= TS_NEW;
            pid_q[idx_q]    <= next_pid_q;
            wake_q[idx_q]   <= '0;
            next_q[idx_q]   <= next_q[cur_q];
            prev_q[idx_q]   <= PtrW'(cur_q);
            if (next_q[cur_q] < Null) begin
              prev_q[next_q[cur_q][IdxW-1:0]] <= PtrW'(idx_q);
            end
            next_q[cur_q] <= PtrW'(idx_q);
            next_pid_q    <= next_pid_q + PidW'(1);
            out_stack_q   <= '0;
            out_created_q <= next_pid_q;
            out_valid_q   <= 1'b1;
          end else if (idx_q == LastIdx) begin
            out_stack_q <= '0;
            out_err_q   <= ERR_FULL;
            out_valid_q <= 1'b1;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        S_WALK: begin
          if (visits_q >= Null) begin
            // A full circle found nothing runnable: fall back to idle.
            cur_q       <= '0;
            status_q[0] <= TS_RUN;
            wake_q[0]   <= '0;
          end else begin
            visits_q <= visits_q + PtrW'(1);
            if (w_end) begin
              if (w_prev < Null) begin
                next_q[w_prev[IdxW-1:0]] <= w_next;
              end
              if (w_next < Null) begin
                prev_q[w_next[IdxW-1:0]] <= w_prev;
              end
              status_q[succ] <= TS_FREE;
              pid_q[succ]    <= '0;
              wake_q[succ]   <= '0;
              next_q[succ]   <= Null;
              prev_q[succ]   <= Null;
              removed_q      <= removed_q + RemovedW'(1);
              cur_q          <= (w_prev < Null) ? w_prev[IdxW-1:0] : '0;
            end else begin
              cur_q <= succ;
              if (w_run) begin
                status_q[succ] <= TS_RUN;
                if (w_st == TS_SLEEP) begin
                  wake_q[succ] <= '0;
                end
              end
            end
          end
        end
        S_READ: begin
        end
        S_LOAD: begin
          out_stack_q   <= ram_rdata;
          out_pid_q     <= pid_q[cur_q];
          out_removed_q <= removed_q;
          out_valid_q   <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_removed_q, out_err_q, out_created_q,
                            out_pid_q, out_stack_q};

  // The idle task can never be ended or freed.
  a_idle_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q[0] != TS_FREE) && (status_q[0] != TS_ENDED))
    else $error("idle task slot lost");

  // The walk never counts past one full circle.
  a_visits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (visits_q <= Null))
    else $error("walk ran past one circle");

  // A result beat is only raised from idle, create search or stack load.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_FIND ||
                            $past(state_q) == S_LOAD))
    else $error("result raised from unexpected state");

endmodule

@@ tb/sv/tb_round_robin_task_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// tb_round_robin_task_scheduler_unit
// Self-checking testbench for the round-robin task scheduler. A behavioral
// task table predicts every result beat, and a monitor compares the beats
// field by field, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_round_robin_task_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam int unsigned NTask = 16;
  localparam int unsigned NullSlot = NTask;
  localparam int unsigned ErrLimit = 10;
  localparam longint unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    logic [4:0]  removed;
    logic [1:0]  err;
    logic [15:0] created;
    logic [15:0] running;
    logic [31:0] stack;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;

  round_robin_task_scheduler_unit #(.MAX_TASKS(NTask)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted scheduler state.
  logic          sched_en;
  task_st_e      tbl_status [NTask];
  logic [15:0]   tbl_pid    [NTask];
  logic [31:0]   tbl_wake   [NTask];
  logic [31:0]   tbl_stack  [NTask];
  int unsigned   tbl_next   [NTask];
  int unsigned   tbl_prev   [NTask];
  int unsigned   cur_slot;
  logic [31:0]   ticks_now;
  logic [15:0]   pid_counter;

  sched_result_t pending_results[$];
  int unsigned   n_mismatch = 0;
  int unsigned   n_beats_in = 0;
  int unsigned   n_beats_out = 0;
  int unsigned   n_removed = 0;
  int unsigned   n_full = 0;
  longint unsigned cycle_cnt = 0;
  bit            rx_stall_on = 1'b1;

  function automatic void model_reset();
    sched_en = 1'b0;
    for (int i = 0; i < NTask; i++) begin
      tbl_status[i] = TS_FREE;
      tbl_pid[i] = '0;
      tbl_wake[i] = '0;
      tbl_stack[i] = '0;
      tbl_next[i] = NullSlot;
      tbl_prev[i] = NullSlot;
    end
    tbl_status[0] = TS_RUN;
    cur_slot = 0;
    ticks_now = '0;
    pid_counter = 16'd1;
  endfunction

  function automatic void unlink_task(int unsigned t);
    int unsigned p;
    int unsigned n;
    p = tbl_prev[t];
    n = tbl_next[t];
    if (p < NTask) tbl_next[p] = n;
    if (n < NTask) tbl_prev[n] = p;
    tbl_status[t] = TS_FREE;
    tbl_pid[t] = '0;
    tbl_wake[t] = '0;
    tbl_next[t] = NullSlot;
    tbl_prev[t] = NullSlot;
  endfunction

  // Saves the caller's stack, walks the ring and returns the resumed stack.
  function automatic logic [31:0] context_switch(logic [31:0] stk,
                                                 ref int unsigned removed);
    int unsigned c;
    int unsigned visits;
    int unsigned p;
    task_st_e st;
    c = cur_slot;
    visits = 0;
    tbl_stack[c] = stk;
    if (tbl_status[c] == TS_RUN) tbl_status[c] = TS_WAIT;
    forever begin
      if (visits >= NTask) begin
        c = 0;
        tbl_status[0] = TS_RUN;
        tbl_wake[0] = '0;
        break;
      end
      visits++;
      c = (tbl_next[c] >= NTask) ? 0 : tbl_next[c];
      st = tbl_status[c];
      if (st == TS_SLEEP) begin
        if (tbl_wake[c] <= ticks_now) begin
          tbl_wake[c] = '0;
          tbl_status[c] = TS_RUN;
        end
      end else if (st == TS_NEW || st == TS_WAIT) begin
        tbl_status[c] = TS_RUN;
      end else if (st == TS_ENDED && c != 0) begin
        p = tbl_prev[c];
        unlink_task(c);
        removed++;
        c = (p < NTask) ? p : 0;
        continue;
      end
      if (tbl_status[c] == TS_RUN) break;
    end
    cur_slot = c;
    return tbl_stack[c];
  endfunction

  function automatic sched_result_t schedule_op(logic [2:0] op, logic [31:0] stk,
                                                logic [31:0] nticks);
    sched_result_t r;
    int unsigned removed;
    int unsigned f;
    int unsigned n;
    int unsigned c;
    removed = 0;
    c = cur_slot;
    r = '0;
    r.stack = stk;
    case (op)
      OP_TICK: begin
        ticks_now = ticks_now + 1;
        if (sched_en) r.stack = context_switch(stk, removed);
      end
      OP_YIELD: begin
        if (sched_en) r.stack = context_switch(stk, removed);
      end
      OP_SLEEP: begin
        if (sched_en) begin
          tbl_status[c] = TS_SLEEP;
          tbl_wake[c] = ticks_now + nticks;
          r.stack = context_switch(stk, removed);
        end
      end
      OP_CREATE: begin
        f = NullSlot;
        for (int i = 1; i < NTask; i++) begin
          if (tbl_status[i] == TS_FREE && f == NullSlot) f = i;
        end
        r.stack = '0;
        if (f == NullSlot) begin
          r.err = ERR_FULL;
        end else begin
          n = tbl_next[c];
          tbl_status[f] = TS_NEW;
          tbl_pid[f] = pid_counter;
          tbl_wake[f] = '0;
          tbl_stack[f] = stk;
          r.created = pid_counter;
          pid_counter = pid_counter + 1;
          tbl_next[f] = n;
          tbl_prev[f] = c;
          if (n < NTask) tbl_prev[n] = f;
          tbl_next[c] = f;
        end
      end
      OP_END: begin
        if (c == 0) begin
          r.err = ERR_IDLE_END;
        end else begin
          tbl_status[c] = TS_ENDED;
          if (sched_en) r.stack = context_switch(stk, removed);
        end
      end
      default: ;
    endcase
    r.running = tbl_pid[cur_slot];
    r.removed = removed[4:0];
    return r;
  endfunction

  // Sends one beat after a random gap (none if no_gap is set) and queues its
  // expected result. The valid stays high after the accepting edge; a following
  // beat with no gap simply replaces the data at the next falling edge.
  task automatic send_op(logic [2:0] op, logic [31:0] stk, logic [31:0] nticks,
                         bit no_gap = 1'b0);
    int unsigned gap;
    sched_result_t r;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {nticks, stk};
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = schedule_op(op, stk, nticks);
    if (r.removed != 0) n_removed++;
    if (r.err == ERR_FULL) n_full++;
    pending_results.push_back(r);
    n_beats_in++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic drain_results();
    release_input();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_enable(bit val);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sched_en = val;
  endtask

  // Result monitor.
  always @(posedge clk_i) begin
    sched_result_t got;
    sched_result_t exp_r;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[70:0];
      n_beats_out++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= ErrLimit) $display("unexpected result beat %h", got);
      end else begin
        exp_r = pending_results.pop_front();
        if (got.stack !== exp_r.stack || got.running !== exp_r.running ||
            got.created !== exp_r.created || got.err !== exp_r.err ||
            got.removed !== exp_r.removed || m_axis_tdata_o[71] !== 1'b0) begin
          n_mismatch++;
          if (n_mismatch <= ErrLimit)
            $display({"beat %0d: expected stk=%h pid=%h new=%h err=%0d rm=%0d,",
                      " got stk=%h pid=%h new=%h err=%0d rm=%0d"},
                     n_beats_out, exp_r.stack, exp_r.running, exp_r.created,
                     exp_r.err, exp_r.removed, got.stack, got.running,
                     got.created, got.err, got.removed);
        end
      end
    end
  end

  // Ready driver: before each result beat the sink waits a drawn number of
  // cycles while rx_stall_on is set, then holds ready until the beat is taken.
  initial begin
    int unsigned wait_n;
    forever begin
      wait_n = rx_stall_on ? $urandom_range(0, 13) : 0;
      if (wait_n != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("round_robin_task_scheduler_unit: mismatch");
      $finish;
    end
  end

  task automatic test_disabled_ops();
    send_op(OP_TICK, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_YIELD, 32'h0, 32'hFFFF_FFFF);
    send_op(OP_SLEEP, 32'h1234_5678, 32'h5);
    send_op(OP_END, 32'hAAAA_5555, 32'h0);
    send_op(3'd5, 32'h5555_AAAA, 32'hFFFF_FFFF);
    send_op(3'd7, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_CREATE, 32'hC0DE_0001, 32'h0);
    send_op(OP_END, 32'h0, 32'h0);
  endtask

  task automatic test_enabled_switching();
    write_enable(1'b1);
    send_op(OP_CREATE, 32'hC0DE_0002, 32'h0);
    send_op(OP_TICK, 32'h1111_0000, 32'h0);
    send_op(OP_YIELD, 32'h2222_0000, 32'h0);
    send_op(OP_SLEEP, 32'h3333_0000, 32'h3);
    send_op(OP_SLEEP, 32'h4444_0000, 32'hFFFF_FFFF);
    send_op(OP_TICK, 32'h5555_0000, 32'h0);
    send_op(OP_END, 32'h6666_0000, 32'h0);
    send_op(OP_YIELD, 32'h7777_0000, 32'h0);
    send_op(3'd6, 32'h8888_0000, 32'h0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NTask; i++) send_op(OP_CREATE, $urandom(), 32'h0);
    repeat (NTask) send_op(OP_END, $urandom(), 32'h0);
  endtask

  // Mostly create/tick/yield/end/short sleeps, rare bad opcodes; gapless bursts.
  task automatic test_random_ops(int unsigned count);
    logic [2:0] op;
    logic [31:0] nt;
    int unsigned k;
    for (int unsigned i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 25) op = OP_TICK;
      else if (k < 40) op = OP_YIELD;
      else if (k < 55) op = OP_SLEEP;
      else if (k < 75) op = OP_CREATE;
      else if (k < 96) op = OP_END;
      else op = 3'($urandom_range(5, 7));
      nt = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 6);
      send_op(op, $urandom(), nt, (i / 64) % 3 == 0);
      if (i == count / 2) begin
        // Hold off until the block has answered everything.
        drain_results();
      end
    end
  endtask

  initial begin
    model_reset();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_disabled_ops();
    test_enabled_switching();
    test_table_full();
    test_random_ops(700);
    write_enable(1'b0);
    test_random_ops(300);
    write_enable(1'b1);
    rx_stall_on = 1'b0;
    test_random_ops(400);
    rx_stall_on = 1'b1;
    test_random_ops(500);
    drain_results();
    $display("Covered %0d beats in and %0d out, enable on and off, full table %0d times,",
             n_beats_in, n_beats_out, n_full);
    $display("and %0d switches that unlinked ended tasks.", n_removed);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("round_robin_task_scheduler_unit: match");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch,
               pending_results.size());
      $display("round_robin_task_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule
